@@ rtl/core/aesc_pkg.sv @@
// Shared types and character constants for the expression syntax checker.
`timescale 1ns / 1ps

package aesc_pkg;

  localparam int unsigned INDEX_W = 16;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_OPEN   = 8'h28;
  localparam logic [7:0] CH_CLOSE  = 8'h29;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  typedef enum logic [1:0] {
    MODE_OPERAND = 2'd0,
    MODE_NUMBER  = 2'd1,
    MODE_IDENT   = 2'd2,
    MODE_AFTER   = 2'd3
  } aesc_mode_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_END   = 3'd1,
    ST_TOKEN = 3'd2,
    ST_CLOSE = 3'd3,
    ST_TRAIL = 3'd4,
    ST_DEEP  = 3'd5
  } aesc_status_t;

  typedef struct packed {
    aesc_mode_t          mode;
    aesc_status_t        err;
    logic [INDEX_W-1:0]  err_index;
    logic [INDEX_W-1:0]  count;
  } aesc_ctrl_t;

  localparam aesc_ctrl_t CTRL_RESET = '{
    mode:      MODE_OPERAND,
    err:       ST_OK,
    err_index: '0,
    count:     '0
  };

endpackage

@@ rtl/core/aesc_char_if.sv @@
// Request channel that carries one expression byte and its last marker.
`timescale 1ns / 1ps

interface aesc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

@@ rtl/core/aesc_verdict_if.sv @@
// Request channel that carries one checker result per input byte.
`timescale 1ns / 1ps

interface aesc_verdict_if;
  logic                           valid;
  logic                           ready;
  logic                           at_end;
  logic [2:0]                     status;
  logic [aesc_pkg::INDEX_W-1:0]   error_index;

  modport source (output valid, output at_end, output status, output error_index,
                  input ready);
  modport sink   (input valid, input at_end, input status, input error_index,
                  output ready);
endinterface

@@ rtl/core/aesc_scan.sv @@
// Next-state logic of the checker for one byte: classification, scan and end check.
`timescale 1ns / 1ps

module aesc_scan #(
  parameter int unsigned                      MAX_DEPTH = 255,
  parameter int unsigned                      DEPTH_W   = 8,
  parameter logic [aesc_pkg::INDEX_W-1:0]     COUNT_CAP = 16'hFFFF
) (
  input  logic [7:0]                      char_code,
  input  logic                            last_char,
  input  aesc_pkg::aesc_ctrl_t            ctrl,
  input  logic [DEPTH_W-1:0]              depth,
  output aesc_pkg::aesc_ctrl_t            ctrl_next,
  output logic [DEPTH_W-1:0]              depth_next,
  output aesc_pkg::aesc_status_t          status,
  output logic [aesc_pkg::INDEX_W-1:0]    error_index
);

  localparam logic [DEPTH_W-1:0] DEPTH_LIMIT = DEPTH_W'(MAX_DEPTH);

  logic is_space;
  logic is_digit;
  logic is_alpha;
  logic is_id_start;
  logic is_id_more;
  logic is_sign;
  logic is_binop;

  aesc_pkg::aesc_mode_t         mode_s;
  aesc_pkg::aesc_status_t       err_s;
  logic [aesc_pkg::INDEX_W-1:0] idx_s;
  logic [aesc_pkg::INDEX_W-1:0] count_inc;
  logic [DEPTH_W-1:0]           depth_s;

  assign is_space    = (char_code == 8'd32) || (char_code >= 8'd9 && char_code <= 8'd13);
  assign is_digit    = (char_code >= 8'd48) && (char_code <= 8'd57);
  assign is_alpha    = (char_code >= 8'd65 && char_code <= 8'd90) ||
                       (char_code >= 8'd97 && char_code <= 8'd122);
  assign is_id_start = is_alpha || (char_code == aesc_pkg::CH_UNDER);
  assign is_id_more  = is_id_start || is_digit;
  assign is_sign     = (char_code == aesc_pkg::CH_PLUS) || (char_code == aesc_pkg::CH_MINUS);
  assign is_binop    = is_sign || (char_code == aesc_pkg::CH_STAR) ||
                       (char_code == aesc_pkg::CH_SLASH);

  assign count_inc = (ctrl.count < COUNT_CAP) ? ctrl.count + 1'b1 : ctrl.count;

  always_comb begin
    mode_s  = ctrl.mode;
    err_s   = ctrl.err;
    idx_s   = ctrl.err_index;
    depth_s = depth;

    if (ctrl.err == aesc_pkg::ST_OK) begin
      if (ctrl.mode == aesc_pkg::MODE_OPERAND) begin
        if (is_space || is_sign) begin
          mode_s = aesc_pkg::MODE_OPERAND;
        end else if (char_code == aesc_pkg::CH_OPEN) begin
          if (depth >= DEPTH_LIMIT) begin
            err_s = aesc_pkg::ST_DEEP;
            idx_s = ctrl.count;
          end else begin
            depth_s = depth + 1'b1;
          end
        end else if (is_digit) begin
          mode_s = aesc_pkg::MODE_NUMBER;
        end else if (is_id_start) begin
          mode_s = aesc_pkg::MODE_IDENT;
        end else begin
          err_s = aesc_pkg::ST_TOKEN;
          idx_s = ctrl.count;
        end
      end else if ((ctrl.mode == aesc_pkg::MODE_NUMBER && is_digit) ||
                   (ctrl.mode == aesc_pkg::MODE_IDENT && is_id_more)) begin
        mode_s = ctrl.mode;
      end else if (is_space) begin
        mode_s = aesc_pkg::MODE_AFTER;
      end else if (is_binop) begin
        mode_s = aesc_pkg::MODE_OPERAND;
      end else if (char_code == aesc_pkg::CH_CLOSE && depth != '0) begin
        depth_s = depth - 1'b1;
        mode_s  = aesc_pkg::MODE_AFTER;
      end else if (depth != '0) begin
        err_s = aesc_pkg::ST_CLOSE;
        idx_s = ctrl.count;
      end else begin
        err_s = aesc_pkg::ST_TRAIL;
        idx_s = ctrl.count;
      end
    end

    if (last_char && err_s == aesc_pkg::ST_OK) begin
      if (mode_s == aesc_pkg::MODE_OPERAND) begin
        err_s = aesc_pkg::ST_END;
        idx_s = count_inc;
      end else if (depth_s != '0) begin
        err_s = aesc_pkg::ST_CLOSE;
        idx_s = count_inc;
      end
    end
  end

  assign status      = err_s;
  assign error_index = idx_s;

  // The final byte returns everything to the reset state.
  always_comb begin
    if (last_char) begin
      ctrl_next  = aesc_pkg::CTRL_RESET;
      depth_next = '0;
    end else begin
      ctrl_next.mode      = mode_s;
      ctrl_next.err       = err_s;
      ctrl_next.err_index = idx_s;
      ctrl_next.count     = count_inc;
      depth_next          = depth_s;
    end
  end

endmodule

@@ rtl/core/arithmetic_expression_syntax_check_core.sv @@
// Top level of the streaming arithmetic expression syntax checker.
`timescale 1ns / 1ps
// Each accepted byte passes through the input register, then the result register.
// Throughput: one byte per cycle unless verdicts stall; a single scan pass per byte.
// Every byte gives exactly one result; the byte marked last gives the final verdict.
// Reset (synchronous, active high) empties both registers and clears the scan state.
// The scan state also returns to its reset value after each final byte.

module arithmetic_expression_syntax_check_core #(
  parameter int unsigned      MAX_DEPTH  = 255,
  parameter longint unsigned  MAX_LENGTH = 65535
) (
  input  logic                  clk,
  input  logic                  rst,
  aesc_char_if.sink             chars,
  aesc_verdict_if.source        verdicts
);

  localparam int unsigned     DEPTH_W   = $clog2(MAX_DEPTH + 1);
  localparam longint unsigned CAP_WIDE  = (MAX_LENGTH < 64'd65535) ? MAX_LENGTH : 64'd65535;
  localparam logic [aesc_pkg::INDEX_W-1:0] COUNT_CAP = CAP_WIDE[aesc_pkg::INDEX_W-1:0];

  logic                              s1_valid;
  logic [7:0]                        s1_char;
  logic                              s1_last;
  logic                              advance;

  aesc_pkg::aesc_ctrl_t              ctrl;
  aesc_pkg::aesc_ctrl_t              ctrl_next;
  logic [DEPTH_W-1:0]                depth;
  logic [DEPTH_W-1:0]                depth_next;
  aesc_pkg::aesc_status_t            status_next;
  logic [aesc_pkg::INDEX_W-1:0]      index_next;

  logic                              out_valid;
  logic                              out_end;
  aesc_pkg::aesc_status_t            out_status;
  logic [aesc_pkg::INDEX_W-1:0]      out_index;

  assign advance     = s1_valid && (!out_valid || verdicts.ready);
  assign chars.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (chars.ready) begin
      s1_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      s1_char <= chars.char_code;
      s1_last <= chars.last_char;
    end
  end

  aesc_scan #(
    .MAX_DEPTH (MAX_DEPTH),
    .DEPTH_W   (DEPTH_W),
    .COUNT_CAP (COUNT_CAP)
  ) u_scan (
    .char_code   (s1_char),
    .last_char   (s1_last),
    .ctrl        (ctrl),
    .depth       (depth),
    .ctrl_next   (ctrl_next),
    .depth_next  (depth_next),
    .status      (status_next),
    .error_index (index_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl  <= aesc_pkg::CTRL_RESET;
      depth <= '0;
    end else if (advance) begin
      ctrl  <= ctrl_next;
      depth <= depth_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || verdicts.ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_end    <= s1_last;
      out_status <= status_next;
      out_index  <= index_next;
    end
  end

  assign verdicts.valid       = out_valid;
  assign verdicts.at_end      = out_end;
  assign verdicts.status      = out_status;
  assign verdicts.error_index = out_index;

  // A final byte leaves the scan state at its reset value.
  assert property (@(posedge clk) disable iff (rst)
    advance && s1_last |=> (ctrl == aesc_pkg::CTRL_RESET) && (depth == '0))
    else $error("scan state not cleared after final byte");

  // The nesting depth never passes its limit.
  assert property (@(posedge clk) disable iff (rst)
    depth <= DEPTH_W'(MAX_DEPTH))
    else $error("nesting depth beyond limit");

  // Once an error is held, it stays until the final byte.
  assert property (@(posedge clk) disable iff (rst)
    advance && !s1_last && ctrl.err != aesc_pkg::ST_OK |=>
      ctrl.err == $past(ctrl.err) && ctrl.err_index == $past(ctrl.err_index))
    else $error("held error changed before final byte");

  // A result without an error carries a zero index.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == aesc_pkg::ST_OK |-> out_index == '0)
    else $error("error index set without an error");

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the streaming arithmetic expression syntax checker.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned DEPTH_LIMIT = 255;
  localparam longint unsigned LENGTH_LIMIT = 65535;
  localparam logic [15:0] COUNT_CAP = (LENGTH_LIMIT < 65535) ? LENGTH_LIMIT[15:0] : 16'hFFFF;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 10;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic                   at_end;
    aesc_pkg::aesc_status_t status;
    logic [15:0]            error_index;
  } verdict_t;

  logic clk;
  logic rst;

  aesc_char_if    char_ch();
  aesc_verdict_if verdict_ch();

  arithmetic_expression_syntax_check_core #(
    .MAX_DEPTH(DEPTH_LIMIT),
    .MAX_LENGTH(LENGTH_LIMIT)
  ) uut (
    .clk(clk),
    .rst(rst),
    .chars(char_ch),
    .verdicts(verdict_ch)
  );

  verdict_t    expected_verdicts[$];
  int unsigned mismatch_count = 0;
  int unsigned verdict_count = 0;
  int unsigned chars_sent = 0;
  int unsigned quiet_cycles = 0;
  bit          idle_on = 1'b1;

  aesc_pkg::aesc_mode_t   scan_mode_q;
  int unsigned            paren_depth_q;
  aesc_pkg::aesc_status_t first_err_q;
  logic [15:0]            first_err_pos_q;
  logic [15:0]            char_count_q;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit is_blank(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic bit is_name_start(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
           c == aesc_pkg::CH_UNDER;
  endfunction

  function automatic void clear_scan();
    scan_mode_q = aesc_pkg::MODE_OPERAND;
    paren_depth_q = 0;
    first_err_q = aesc_pkg::ST_OK;
    first_err_pos_q = '0;
    char_count_q = '0;
  endfunction

  function automatic void note_error(aesc_pkg::aesc_status_t code, logic [15:0] pos);
    if (first_err_q == aesc_pkg::ST_OK) begin
      first_err_q = code;
      first_err_pos_q = pos;
    end
  endfunction

  function automatic void scan_char(logic [7:0] c, logic [15:0] pos);
    if (scan_mode_q == aesc_pkg::MODE_OPERAND) begin
      if (is_blank(c) || c == aesc_pkg::CH_PLUS || c == aesc_pkg::CH_MINUS) return;
      if (c == aesc_pkg::CH_OPEN) begin
        if (paren_depth_q >= DEPTH_LIMIT) note_error(aesc_pkg::ST_DEEP, pos);
        else paren_depth_q++;
      end else if (is_digit(c)) begin
        scan_mode_q = aesc_pkg::MODE_NUMBER;
      end else if (is_name_start(c)) begin
        scan_mode_q = aesc_pkg::MODE_IDENT;
      end else begin
        note_error(aesc_pkg::ST_TOKEN, pos);
      end
      return;
    end
    if (scan_mode_q == aesc_pkg::MODE_NUMBER && is_digit(c)) return;
    if (scan_mode_q == aesc_pkg::MODE_IDENT && (is_name_start(c) || is_digit(c))) return;
    if (is_blank(c)) begin
      scan_mode_q = aesc_pkg::MODE_AFTER;
    end else if (c == aesc_pkg::CH_PLUS || c == aesc_pkg::CH_MINUS ||
                 c == aesc_pkg::CH_STAR || c == aesc_pkg::CH_SLASH) begin
      scan_mode_q = aesc_pkg::MODE_OPERAND;
    end else if (c == aesc_pkg::CH_CLOSE && paren_depth_q > 0) begin
      paren_depth_q--;
      scan_mode_q = aesc_pkg::MODE_AFTER;
    end else if (paren_depth_q > 0) begin
      note_error(aesc_pkg::ST_CLOSE, pos);
    end else begin
      note_error(aesc_pkg::ST_TRAIL, pos);
    end
  endfunction

  function automatic void predict_verdict(logic [7:0] c, logic last);
    logic [15:0] pos;
    verdict_t    v;
    pos = char_count_q;
    if (char_count_q < COUNT_CAP) char_count_q++;
    if (first_err_q == aesc_pkg::ST_OK) scan_char(c, pos);
    if (last && first_err_q == aesc_pkg::ST_OK) begin
      if (scan_mode_q == aesc_pkg::MODE_OPERAND) note_error(aesc_pkg::ST_END, char_count_q);
      else if (paren_depth_q > 0) note_error(aesc_pkg::ST_CLOSE, char_count_q);
    end
    v.at_end = last;
    v.status = first_err_q;
    v.error_index = first_err_pos_q;
    expected_verdicts.insert(expected_verdicts.size(), v);
    if (last) clear_scan();
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("ERROR result %0d %s: got %0d, want %0d", verdict_count, what, got, want);
    end
  endtask

  task automatic send_char(logic [7:0] c, logic last);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      char_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    char_ch.valid <= 1'b1;
    char_ch.char_code <= c;
    char_ch.last_char <= last;
    @(posedge clk);
    while (!char_ch.ready) @(posedge clk);
    chars_sent++;
    predict_verdict(c, last);
  endtask

  task automatic send_text(string s, bit ends = 1'b1);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i], ends && i == s.len() - 1);
  endtask

  task automatic send_bytes(byte_q_t q, bit ends = 1'b1);
    int i;
    for (i = 0; i < q.size(); i++) send_char(q[i], ends && i == q.size() - 1);
  endtask

  task automatic wait_drain();
    char_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_verdicts.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] name_char(bit more);
    int unsigned r;
    r = $urandom_range(0, more ? 62 : 52);
    if (r < 26) return 8'(32'h41 + r);
    if (r < 52) return 8'(32'h61 + r - 26);
    if (r == 52) return aesc_pkg::CH_UNDER;
    return 8'(32'h30 + r - 53);
  endfunction

  function automatic void add_blanks(ref byte_q_t q);
    int unsigned r;
    while ($urandom_range(0, 3) == 0) begin
      r = $urandom_range(8, 13);
      q.insert(q.size(), r == 8 ? 8'h20 : 8'(r));
    end
  endfunction

  function automatic void build_expression(ref byte_q_t q);
    int unsigned open_count;
    int unsigned terms;
    int unsigned t;
    q.delete();
    open_count = 0;
    terms = $urandom_range(1, 6);
    for (t = 0; t < terms; t++) begin
      if (t != 0) begin
        case ($urandom_range(0, 3))
          0: q.insert(q.size(), aesc_pkg::CH_PLUS);
          1: q.insert(q.size(), aesc_pkg::CH_MINUS);
          2: q.insert(q.size(), aesc_pkg::CH_STAR);
          default: q.insert(q.size(), aesc_pkg::CH_SLASH);
        endcase
      end
      add_blanks(q);
      while ($urandom_range(0, 3) == 0) begin
        q.insert(q.size(), $urandom_range(0, 1) ? aesc_pkg::CH_PLUS : aesc_pkg::CH_MINUS);
      end
      while ($urandom_range(0, 2) == 0 && open_count < 6) begin
        q.insert(q.size(), aesc_pkg::CH_OPEN);
        open_count++;
        add_blanks(q);
      end
      if ($urandom_range(0, 1)) begin
        repeat ($urandom_range(1, 3)) q.insert(q.size(), 8'(32'h30 + $urandom_range(0, 9)));
      end else begin
        q.insert(q.size(), name_char(1'b0));
        repeat ($urandom_range(0, 3)) q.insert(q.size(), name_char(1'b1));
      end
      add_blanks(q);
      while (open_count > 0 && $urandom_range(0, 1) == 0) begin
        q.insert(q.size(), aesc_pkg::CH_CLOSE);
        open_count--;
        add_blanks(q);
      end
    end
    while (open_count > 0) begin
      q.insert(q.size(), aesc_pkg::CH_CLOSE);
      open_count--;
    end
  endfunction

  task automatic test_directed();
    idle_on = 1'b1;
    send_text("A_z9/(0)");
    send_text("1+");
    send_text("(9");
    send_text(")");
    send_text("1)");
    send_text("(1#");
    send_char("1", 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);
    send_char(8'h09, 1'b0);
    send_char(8'h0B, 1'b0);
    send_char(8'h0D, 1'b0);
    send_char("7", 1'b1);
    send_text(" \n-b", 1'b0);
    send_char(8'h80, 1'b1);
  endtask

  task automatic test_nesting_limit();
    idle_on = 1'b1;
    repeat (DEPTH_LIMIT) send_char(aesc_pkg::CH_OPEN, 1'b0);
    send_char("5", 1'b0);
    repeat (DEPTH_LIMIT - 1) send_char(aesc_pkg::CH_CLOSE, 1'b0);
    send_char(aesc_pkg::CH_CLOSE, 1'b1);
    repeat (DEPTH_LIMIT + 1) send_char(aesc_pkg::CH_OPEN, 1'b0);
    send_text("x))", 1'b1);
  endtask

  task automatic test_drain_pause();
    byte_q_t expr;
    int      cut;
    int      i;
    idle_on = 1'b1;
    repeat (3) begin
      build_expression(expr);
      cut = expr.size() / 2;
      for (i = 0; i < cut; i++) send_char(expr[i], 1'b0);
      wait_drain();
      for (i = cut; i < expr.size(); i++) send_char(expr[i], i == expr.size() - 1);
    end
  endtask

  task automatic test_random_expressions();
    byte_q_t     expr;
    int unsigned stop_at;
    int unsigned kind;
    stop_at = chars_sent + 150;
    while (chars_sent < stop_at) begin
      idle_on = $urandom_range(0, 3) != 0;
      build_expression(expr);
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        expr.delete();
        repeat ($urandom_range(1, 6)) expr.insert(expr.size(), 8'($urandom_range(0, 255)));
      end else if (kind <= 2) begin
        expr[$urandom_range(0, expr.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (kind == 3 && expr.size() > 1) begin
        repeat ($urandom_range(1, expr.size() - 1)) void'(expr.pop_back());
      end else if (kind == 4) begin
        expr.insert($urandom_range(0, expr.size()), 8'($urandom_range(0, 255)));
      end
      send_bytes(expr);
    end
  endtask

  task automatic test_back_to_back();
    byte_q_t     expr;
    int unsigned stop_at;
    idle_on = 1'b0;
    stop_at = chars_sent + 100;
    while (chars_sent < stop_at) begin
      build_expression(expr);
      send_bytes(expr);
    end
  endtask

  initial begin
    verdict_ch.ready <= 1'b0;
    forever begin
      int unsigned stall_left;
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        verdict_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 2);
        verdict_ch.ready <= 1'b0;
      end else begin
        verdict_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && verdict_ch.valid && verdict_ch.ready) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch("arrived with nothing pending, status", verdict_ch.status, 0);
      end else begin
        want = expected_verdicts.pop_front();
        if (verdict_ch.at_end !== want.at_end)
          report_mismatch("at_end", verdict_ch.at_end, want.at_end);
        if (verdict_ch.status !== want.status)
          report_mismatch("status", verdict_ch.status, want.status);
        if (verdict_ch.error_index !== want.error_index)
          report_mismatch("error_index", verdict_ch.error_index, want.error_index);
      end
      verdict_count++;
    end
  end

  always @(posedge clk) begin
    if ((char_ch.valid && char_ch.ready) || (verdict_ch.valid && verdict_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("arithmetic_expression_syntax_check_core: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    char_ch.valid <= 1'b0;
    char_ch.char_code <= 8'h00;
    char_ch.last_char <= 1'b0;
    clear_scan();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_nesting_limit();
    test_drain_pause();
    test_random_expressions();
    test_back_to_back();
    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("arithmetic_expression_syntax_check_core: match");
    end else begin
      $display("arithmetic_expression_syntax_check_core: mismatch");
    end
    $finish;
  end

endmodule
